@@ rtl/plane_to_stereo_pixel_projection_unit_assert.svh @@
// assertion macros used by the projection unit port checker
`ifndef PLANE_TO_STEREO_PIXEL_PROJECTION_UNIT_ASSERT_SVH
`define PLANE_TO_STEREO_PIXEL_PROJECTION_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define PSPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define PSPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pspp_pkg.sv @@
// types, constants and helpers of the plane to stereo pixel projection unit
`timescale 1ns / 1ps
`default_nettype none

package pspp_pkg;

  localparam int GRID_SIZE = 256;

  localparam int COORD_W = 15;
  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  localparam int NUM_W   = 57;  // signed plane numerator
  localparam int MAG_W   = 56;  // its magnitude
  localparam int SCL_W   = 46;  // coefficient times pitch
  localparam int VEC_W   = 39;  // x, y and |x - baseline|
  localparam int PROD_W  = 70;  // focal length times vector
  localparam int DEPTH_W = 47;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  localparam int DIV_REM_W = 64;
  localparam int DIV_DEN_W = 63;
  localparam int DIV_Q_W   = 47;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DEPTH_STEPS = 6'd47;
  localparam logic [DIV_CNT_W-1:0] PRJ_STEPS   = 6'd15;

  localparam int CFG_IDX_W = 3;
  localparam logic [1:0] PRJ_LAST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_A,
    CFG_PLANE_B,
    CFG_PLANE_C,
    CFG_PLANE_D,
    CFG_PIXEL_PITCH,
    CFG_FOCAL_LENGTH,
    CFG_STEREO_BASELINE
  } cfg_idx_e;

  localparam logic [31:0] PLANE_A_RST  = 32'h0000_0000;
  localparam logic [31:0] PLANE_B_RST  = 32'h0000_0000;
  localparam logic [31:0] PLANE_C_RST  = 32'h0001_0000;
  localparam logic [31:0] PLANE_D_RST  = 32'hFFFF_0000;
  localparam logic [30:0] PITCH_RST    = 31'h0001_0000;
  localparam logic [30:0] FOCAL_RST    = 31'h0001_0000;
  localparam logic [30:0] BASELINE_RST = 31'h0001_0000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SA,    // |a| * pitch
    ST_SB,    // |b| * pitch
    ST_SX,    // x = pitch * col
    ST_SY,    // y = pitch * row
    ST_AL,
    ST_AH,
    ST_BL,
    ST_BH,
    ST_LL,    // focal * x
    ST_LH,
    ST_RL,    // focal * |x - baseline|
    ST_RH,
    ST_WL,    // focal * y
    ST_WH,
    ST_DZ,
    ST_DZW,
    ST_PRJ,
    ST_PRJW,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic [7:0] grid_col;
    logic [7:0] grid_row;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] left_column;
    logic [COORD_W-1:0] right_column;
    logic [COORD_W-1:0] image_row;
    logic [COORD_W-1:0] max_left_column;
    logic [COORD_W-1:0] max_right_column;
    logic [COORD_W-1:0] max_image_row;
    logic               divide_fault;
  } out_item_t;

  typedef struct packed {
    st_e        st;
    logic       div_start;
    logic       div_depth;
    logic [1:0] prj_idx;
    logic       out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic c_zero;
    logic depth_zero;
    logic div_done;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

  function automatic logic [7:0] clamp_idx(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (int'(v) > GRID_SIZE - 1) begin
      r = 8'(GRID_SIZE - 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pspp_div.sv @@
// shared radix-2 restoring divider with saturation detect
`timescale 1ns / 1ps
`default_nettype none

module pspp_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [pspp_pkg::DIV_REM_W-1:0]      rem0_i,
  input  wire logic [pspp_pkg::DIV_Q_W-1:0]        low_i,
  input  wire logic [pspp_pkg::DIV_DEN_W-1:0]      den_i,
  input  wire logic [pspp_pkg::DIV_CNT_W-1:0]      steps_i,
  output      logic [pspp_pkg::DIV_Q_W-1:0]        quo_o,
  output      pspp_pkg::div_stat_t                 stat_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic                              sat_q, sat_d;
  logic [pspp_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [pspp_pkg::DIV_REM_W-1:0]    rem_q, rem_d;
  logic [pspp_pkg::DIV_Q_W-1:0]      low_q, low_d;
  logic [pspp_pkg::DIV_DEN_W-1:0]    den_q, den_d;
  logic [pspp_pkg::DIV_Q_W-1:0]      quo_q, quo_d;
  logic [pspp_pkg::DIV_REM_W-1:0]    rem_sh;
  logic                              ge;

  // remainder stays below the divisor, so its top bit is free for the shift
  assign rem_sh = {rem_q[pspp_pkg::DIV_REM_W-2:0], low_q[pspp_pkg::DIV_Q_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      sat_d  = (rem0_i >= {1'b0, den_i});
      cnt_d  = steps_i;
      rem_d  = rem0_i;
      low_d  = low_i;
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      low_d = {low_q[pspp_pkg::DIV_Q_W-2:0], 1'b0};
      quo_d = {quo_q[pspp_pkg::DIV_Q_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == pspp_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o       = quo_q;
  assign stat_o.done = done_q;
  assign stat_o.sat  = sat_q;

endmodule

`default_nettype wire

@@ rtl/pspp_ctrl.sv @@
// sequencer stepping the multiplier and the shared divider through one item
`timescale 1ns / 1ps
`default_nettype none

module pspp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pspp_pkg::stat_t stat_i,
  output      pspp_pkg::ctrl_t ctrl_o
);

  pspp_pkg::st_e st_q, st_d;
  logic [1:0]    k_q, k_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pspp_pkg::ST_IDLE;
      k_q  <= '0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
    end
  end

  always_comb begin
    st_d           = st_q;
    k_d            = k_q;
    ctrl_o         = '0;
    ctrl_o.st      = st_q;
    ctrl_o.prj_idx = k_q;
    case (st_q)
      pspp_pkg::ST_IDLE: begin
        if (stat_i.in_fire) begin
          st_d = pspp_pkg::ST_SA;
        end
      end
      pspp_pkg::ST_SA: st_d = pspp_pkg::ST_SB;
      pspp_pkg::ST_SB: st_d = pspp_pkg::ST_SX;
      pspp_pkg::ST_SX: st_d = pspp_pkg::ST_SY;
      pspp_pkg::ST_SY: st_d = pspp_pkg::ST_AL;
      pspp_pkg::ST_AL: st_d = pspp_pkg::ST_AH;
      pspp_pkg::ST_AH: st_d = pspp_pkg::ST_BL;
      pspp_pkg::ST_BL: st_d = pspp_pkg::ST_BH;
      pspp_pkg::ST_BH: st_d = pspp_pkg::ST_LL;
      pspp_pkg::ST_LL: st_d = pspp_pkg::ST_LH;
      pspp_pkg::ST_LH: st_d = pspp_pkg::ST_RL;
      pspp_pkg::ST_RL: st_d = pspp_pkg::ST_RH;
      pspp_pkg::ST_RH: st_d = pspp_pkg::ST_WL;
      pspp_pkg::ST_WL: st_d = pspp_pkg::ST_WH;
      pspp_pkg::ST_WH: st_d = pspp_pkg::ST_DZ;
      pspp_pkg::ST_DZ: begin
        if (stat_i.c_zero) begin
          st_d = pspp_pkg::ST_OUT;
        end else begin
          ctrl_o.div_start = 1'b1;
          ctrl_o.div_depth = 1'b1;
          st_d             = pspp_pkg::ST_DZW;
        end
      end
      pspp_pkg::ST_DZW: begin
        if (stat_i.div_done) begin
          if (stat_i.depth_zero) begin
            st_d = pspp_pkg::ST_OUT;
          end else begin
            k_d  = '0;
            st_d = pspp_pkg::ST_PRJ;
          end
        end
      end
      pspp_pkg::ST_PRJ: begin
        ctrl_o.div_start = 1'b1;
        st_d             = pspp_pkg::ST_PRJW;
      end
      pspp_pkg::ST_PRJW: begin
        if (stat_i.div_done) begin
          if (k_q == pspp_pkg::PRJ_LAST) begin
            st_d = pspp_pkg::ST_OUT;
          end else begin
            k_d  = k_q + 2'd1;
            st_d = pspp_pkg::ST_PRJ;
          end
        end
      end
      pspp_pkg::ST_OUT: begin
        ctrl_o.out_load = stat_i.out_free;
        if (stat_i.out_free) begin
          st_d = pspp_pkg::ST_IDLE;
        end
      end
      default: st_d = pspp_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/plane_to_stereo_pixel_projection_unit.sv @@
// plane to stereo pixel projection unit: config, multiplier datapath, output register
// a 47-step depth division and three 15-step projections share one radix-2 divider,
// products come from one 32x32 multiplier; the division is skipped when plane_c is zero
// and the projections when plane_c is zero or the depth truncates to zero
// one item at a time: input is not ready until the result is in the output register
// reset restores the register defaults and clears the three running maxima
`timescale 1ns / 1ps
`default_nettype none

module plane_to_stereo_pixel_projection_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire pspp_pkg::in_item_t                 in_item_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      pspp_pkg::out_item_t                out_item_o,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [pspp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [31:0]                        cfg_data_i
);

  pspp_pkg::ctrl_t     ctrl;
  pspp_pkg::stat_t     stat;
  pspp_pkg::div_stat_t div_stat;

  logic [31:0] plane_a_q, plane_b_q, plane_c_q, plane_d_q;
  logic [30:0] pitch_q, focal_q, baseline_q;

  logic [7:0]                       col_q, row_q;
  logic [63:0]                      prod_q, mul_res;
  logic [31:0]                      op_a, op_b;
  logic [pspp_pkg::SCL_W-1:0]       ascl_q, bscl_q;
  logic [pspp_pkg::VEC_W-1:0]       x_q, y_q, xb;
  logic [pspp_pkg::NUM_W-1:0]       num_q, num_abs, num_term;
  logic                             num_neg;
  logic [pspp_pkg::MAG_W-1:0]       mag;
  logic [pspp_pkg::PROD_W-1:0]      prj_q [3];
  logic [pspp_pkg::PROD_W-1:0]      prj_sel, prod_lo, prod_hi;
  logic [pspp_pkg::DEPTH_W-1:0]     depth_q, depth_val;
  logic [pspp_pkg::COORD_W-1:0]     coord_q [3];
  logic [pspp_pkg::COORD_W-1:0]     coord_val;
  logic [pspp_pkg::COORD_W-1:0]     peak_left_q, peak_right_q, peak_row_q;
  logic [pspp_pkg::COORD_W-1:0]     peak_left_d, peak_right_d, peak_row_d;
  logic                             fault_q;
  logic [31:0]                      a_mag, b_mag, c_mag;
  logic                             in_fire;

  logic [pspp_pkg::DIV_REM_W-1:0]   div_rem0;
  logic [pspp_pkg::DIV_Q_W-1:0]     div_low;
  logic [pspp_pkg::DIV_DEN_W-1:0]   div_den;
  logic [pspp_pkg::DIV_CNT_W-1:0]   div_steps;
  logic [pspp_pkg::DIV_Q_W-1:0]     div_quo;

  logic                             out_valid_q;
  pspp_pkg::out_item_t              out_q;

  // configuration is to be written only while idle; the block itself does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_a_q  <= pspp_pkg::PLANE_A_RST;
      plane_b_q  <= pspp_pkg::PLANE_B_RST;
      plane_c_q  <= pspp_pkg::PLANE_C_RST;
      plane_d_q  <= pspp_pkg::PLANE_D_RST;
      pitch_q    <= pspp_pkg::PITCH_RST;
      focal_q    <= pspp_pkg::FOCAL_RST;
      baseline_q <= pspp_pkg::BASELINE_RST;
    end else if (cfg_valid_i) begin
      case (pspp_pkg::cfg_idx_e'(cfg_index_i))
        pspp_pkg::CFG_PLANE_A:         plane_a_q  <= cfg_data_i;
        pspp_pkg::CFG_PLANE_B:         plane_b_q  <= cfg_data_i;
        pspp_pkg::CFG_PLANE_C:         plane_c_q  <= cfg_data_i;
        pspp_pkg::CFG_PLANE_D:         plane_d_q  <= cfg_data_i;
        pspp_pkg::CFG_PIXEL_PITCH:     pitch_q    <= cfg_data_i[30:0];
        pspp_pkg::CFG_FOCAL_LENGTH:    focal_q    <= cfg_data_i[30:0];
        pspp_pkg::CFG_STEREO_BASELINE: baseline_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign a_mag = plane_a_q[31] ? (32'd0 - plane_a_q) : plane_a_q;
  assign b_mag = plane_b_q[31] ? (32'd0 - plane_b_q) : plane_b_q;
  assign c_mag = plane_c_q[31] ? (32'd0 - plane_c_q) : plane_c_q;

  assign in_ready_o = (ctrl.st == pspp_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // shared multiplier, one product per cycle
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.st)
      pspp_pkg::ST_SA: begin op_a = a_mag;             op_b = {1'b0, pitch_q};       end
      pspp_pkg::ST_SB: begin op_a = b_mag;             op_b = {1'b0, pitch_q};       end
      pspp_pkg::ST_SX: begin op_a = {1'b0, pitch_q};   op_b = {24'd0, col_q};        end
      pspp_pkg::ST_SY: begin op_a = {1'b0, pitch_q};   op_b = {24'd0, row_q};        end
      pspp_pkg::ST_AL: begin op_a = ascl_q[31:0];      op_b = {24'd0, col_q};        end
      pspp_pkg::ST_AH: begin op_a = {18'd0, ascl_q[45:32]}; op_b = {24'd0, col_q};   end
      pspp_pkg::ST_BL: begin op_a = bscl_q[31:0];      op_b = {24'd0, row_q};        end
      pspp_pkg::ST_BH: begin op_a = {18'd0, bscl_q[45:32]}; op_b = {24'd0, row_q};   end
      pspp_pkg::ST_LL: begin op_a = {1'b0, focal_q};   op_b = x_q[31:0];             end
      pspp_pkg::ST_LH: begin op_a = {1'b0, focal_q};   op_b = {25'd0, x_q[38:32]};   end
      pspp_pkg::ST_RL: begin op_a = {1'b0, focal_q};   op_b = xb[31:0];              end
      pspp_pkg::ST_RH: begin op_a = {1'b0, focal_q};   op_b = {25'd0, xb[38:32]};    end
      pspp_pkg::ST_WL: begin op_a = {1'b0, focal_q};   op_b = y_q[31:0];             end
      pspp_pkg::ST_WH: begin op_a = {1'b0, focal_q};   op_b = {25'd0, y_q[38:32]};   end
      default: ;
    endcase
  end

  assign mul_res = 64'(op_a) * 64'(op_b);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_res;
  end

  assign xb = (x_q >= {8'd0, baseline_q}) ? (x_q - {8'd0, baseline_q})
                                          : ({8'd0, baseline_q} - x_q);

  // signed numerator: product of the previous cycle, low or high half
  always_comb begin
    num_term = {1'b0, prod_q[55:0]};
    num_neg  = plane_a_q[31];
    case (ctrl.st)
      pspp_pkg::ST_BL: num_term = {prod_q[24:0], 32'd0};
      pspp_pkg::ST_BH: num_neg  = plane_b_q[31];
      pspp_pkg::ST_LL: begin
        num_term = {prod_q[24:0], 32'd0};
        num_neg  = plane_b_q[31];
      end
      default: ;
    endcase
  end

  assign prod_lo = {6'd0, prod_q};
  assign prod_hi = {prod_q[37:0], 32'd0};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      col_q <= pspp_pkg::clamp_idx(in_item_i.grid_col);
      row_q <= pspp_pkg::clamp_idx(in_item_i.grid_row);
      num_q <= {{(pspp_pkg::NUM_W-32){plane_d_q[31]}}, plane_d_q};
    end
    case (ctrl.st)
      pspp_pkg::ST_SB: ascl_q <= prod_q[61:16];
      pspp_pkg::ST_SX: bscl_q <= prod_q[61:16];
      pspp_pkg::ST_SY: x_q    <= prod_q[38:0];
      pspp_pkg::ST_AL: y_q    <= prod_q[38:0];
      pspp_pkg::ST_AH, pspp_pkg::ST_BL, pspp_pkg::ST_BH, pspp_pkg::ST_LL: begin
        num_q <= num_neg ? (num_q - num_term) : (num_q + num_term);
      end
      pspp_pkg::ST_LH: prj_q[0] <= prod_lo;
      pspp_pkg::ST_RL: prj_q[0] <= prj_q[0] + prod_hi;
      pspp_pkg::ST_RH: prj_q[1] <= prod_lo;
      pspp_pkg::ST_WL: prj_q[1] <= prj_q[1] + prod_hi;
      pspp_pkg::ST_WH: prj_q[2] <= prod_lo;
      pspp_pkg::ST_DZ: prj_q[2] <= prj_q[2] + prod_hi;
      pspp_pkg::ST_DZW: begin
        if (div_stat.done) begin
          depth_q <= depth_val;
        end
      end
      pspp_pkg::ST_PRJW: begin
        if (div_stat.done) begin
          coord_q[ctrl.prj_idx] <= coord_val;
        end
      end
      default: ;
    endcase
  end

  assign num_abs = num_q[pspp_pkg::NUM_W-1] ? (pspp_pkg::NUM_W'(0) - num_q) : num_q;
  assign mag     = num_abs[pspp_pkg::MAG_W-1:0];
  assign prj_sel = prj_q[ctrl.prj_idx];

  // depth = |num| * 2^16 / |c|; coordinate = focal * v / (depth * 2^16)
  always_comb begin
    if (ctrl.div_depth) begin
      div_rem0  = {39'd0, mag[55:31]};
      div_low   = {mag[30:0], 16'd0};
      div_den   = {31'd0, c_mag};
      div_steps = pspp_pkg::DEPTH_STEPS;
    end else begin
      div_rem0  = {9'd0, prj_sel[69:15]};
      div_low   = {prj_sel[14:0], 32'd0};
      div_den   = {depth_q, 16'd0};
      div_steps = pspp_pkg::PRJ_STEPS;
    end
  end

  pspp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .rem0_i  (div_rem0),
    .low_i   (div_low),
    .den_i   (div_den),
    .steps_i (div_steps),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  assign depth_val = div_stat.sat ? pspp_pkg::DEPTH_MAX : div_quo;
  assign coord_val = div_stat.sat ? pspp_pkg::COORD_MAX : div_quo[pspp_pkg::COORD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= 1'b0;
    end else if (in_fire) begin
      fault_q <= 1'b0;
    end else if ((ctrl.st == pspp_pkg::ST_DZ) && stat.c_zero) begin
      fault_q <= 1'b1;
    end else if ((ctrl.st == pspp_pkg::ST_DZW) && stat.div_done && stat.depth_zero) begin
      fault_q <= 1'b1;
    end
  end

  assign stat.in_fire    = in_fire;
  assign stat.c_zero     = (plane_c_q == 32'd0);
  assign stat.depth_zero = !div_stat.sat && (div_quo == '0);
  assign stat.div_done   = div_stat.done;
  assign stat.out_free   = !out_valid_q || out_ready_i;

  pspp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // running maxima only move on a good item
  always_comb begin
    peak_left_d  = peak_left_q;
    peak_right_d = peak_right_q;
    peak_row_d   = peak_row_q;
    if (!fault_q) begin
      if (coord_q[0] > peak_left_q)  peak_left_d  = coord_q[0];
      if (coord_q[1] > peak_right_q) peak_right_d = coord_q[1];
      if (coord_q[2] > peak_row_q)   peak_row_d   = coord_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_left_q  <= '0;
      peak_right_q <= '0;
      peak_row_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctrl.out_load) begin
        peak_left_q  <= peak_left_d;
        peak_right_q <= peak_right_d;
        peak_row_q   <= peak_row_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_q.left_column      <= fault_q ? pspp_pkg::COORD_MAX : coord_q[0];
      out_q.right_column     <= fault_q ? pspp_pkg::COORD_MAX : coord_q[1];
      out_q.image_row        <= fault_q ? pspp_pkg::COORD_MAX : coord_q[2];
      out_q.max_left_column  <= peak_left_d;
      out_q.max_right_column <= peak_right_d;
      out_q.max_image_row    <= peak_row_d;
      out_q.divide_fault     <= fault_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/pspp_checker.sv @@
// port-level checker for the projection unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "plane_to_stereo_pixel_projection_unit_assert.svh"

module pspp_port_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire pspp_pkg::out_item_t out_item_o
);

  logic                in_fire;
  logic                out_fault;
  logic                out_good;
  logic                fault_sat;
  logic                max_cover;
  logic                max_mono;
  logic                hold_ok;
  logic                both_valid;
  logic                prev_valid_q;
  logic                prev_stall_q;
  pspp_pkg::out_item_t prev_item_q;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fault = out_valid_o && out_item_o.divide_fault;
  assign out_good  = out_valid_o && !out_item_o.divide_fault;
  assign fault_sat = (out_item_o.left_column == pspp_pkg::COORD_MAX) &&
                     (out_item_o.right_column == pspp_pkg::COORD_MAX) &&
                     (out_item_o.image_row == pspp_pkg::COORD_MAX);
  assign max_cover = (out_item_o.max_left_column >= out_item_o.left_column) &&
                     (out_item_o.max_right_column >= out_item_o.right_column) &&
                     (out_item_o.max_image_row >= out_item_o.image_row);
  assign max_mono  = (out_item_o.max_left_column >= prev_item_q.max_left_column) &&
                     (out_item_o.max_right_column >= prev_item_q.max_right_column) &&
                     (out_item_o.max_image_row >= prev_item_q.max_image_row);
  assign hold_ok    = out_valid_o && (out_item_o == prev_item_q);
  assign both_valid = out_valid_o && prev_valid_q;

  // previous cycle's view of the result channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      prev_stall_q <= 1'b0;
    end else begin
      prev_valid_q <= out_valid_o;
      prev_stall_q <= out_valid_o && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_item_q <= out_item_o;
  end

  // one item in flight: no accept right after an accept
  `PSPP_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_fire, !in_ready_o, "accept while busy")

  // a faulted item shows saturated coordinates
  `PSPP_ASSERT_IMP(a_fault_sat, clk_i, rst_ni, out_fault, fault_sat, "fault not saturated")

  // maxima cover the item they go with
  `PSPP_ASSERT_IMP(a_max_cover, clk_i, rst_ni, out_good, max_cover, "maximum below coordinate")

  // maxima never fall between shown results
  `PSPP_ASSERT_IMP(a_max_mono, clk_i, rst_ni, both_valid, max_mono, "running maximum decreased")

  // stalled result holds
  `PSPP_ASSERT_IMP(a_out_hold, clk_i, rst_ni, prev_stall_q, hold_ok, "stalled item changed")

endmodule

bind plane_to_stereo_pixel_projection_unit pspp_port_checker u_pspp_checker (.*);

`default_nettype wire

@@ tb/pspp_checker.sv @@
// result checker for the plane to stereo pixel projection unit
`timescale 1ns / 1ps

module pspp_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  pspp_pkg::in_item_t               in_item_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  pspp_pkg::out_item_t              out_item_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [pspp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  output int                               mismatches_o,
  output int                               outstanding_o
);

  import pspp_pkg::*;

  logic [31:0] plane_a_q, plane_b_q, plane_c_q, plane_d_q;
  logic [30:0] pitch_q, focal_q, baseline_q;
  logic [COORD_W-1:0] peak_left_q, peak_right_q, peak_row_q;

  out_item_t expected_px[$];
  int mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic logic [63:0] magnitude_of(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // coefficient times pitch, truncated toward zero back to Q16.16
  function automatic longint scaled_coef(logic [31:0] coef);
    longint      sc;
    logic [63:0] m;
    sc = longint'($signed(coef));
    m  = (magnitude_of(sc) * 64'(pitch_q)) >> 16;
    return (sc < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [COORD_W-1:0] project_coord(logic [63:0] vec, logic [63:0] depth);
    logic [127:0] quo;
    quo = (128'(focal_q) * 128'(vec)) / (128'(depth) << 16);
    return (quo > 128'(COORD_MAX)) ? COORD_MAX : quo[COORD_W-1:0];
  endfunction

  // works out one pixel and advances the running maxima
  function automatic out_item_t predict_pixel(in_item_t pt);
    out_item_t    r;
    int           col, row;
    longint       num;
    logic [63:0]  c_mag, depth, x, y, xb;
    logic [127:0] quo;
    logic         fault;
    col = pt.grid_col;
    row = pt.grid_row;
    if (col >= GRID_SIZE) col = GRID_SIZE - 1;
    if (row >= GRID_SIZE) row = GRID_SIZE - 1;
    num = scaled_coef(plane_a_q) * longint'(col) + scaled_coef(plane_b_q) * longint'(row)
        + longint'($signed(plane_d_q));
    c_mag = magnitude_of(longint'($signed(plane_c_q)));
    fault = (c_mag == 0);
    depth = '0;
    r.left_column  = COORD_MAX;
    r.right_column = COORD_MAX;
    r.image_row    = COORD_MAX;
    if (!fault) begin
      quo   = (128'(magnitude_of(num)) << 16) / 128'(c_mag);
      depth = (quo > 128'(DEPTH_MAX)) ? 64'(DEPTH_MAX) : quo[63:0];
      fault = (depth == 0);
    end
    if (!fault) begin
      x  = 64'(pitch_q) * 64'(col);
      y  = 64'(pitch_q) * 64'(row);
      xb = (x >= 64'(baseline_q)) ? x - 64'(baseline_q) : 64'(baseline_q) - x;
      r.left_column  = project_coord(x, depth);
      r.right_column = project_coord(xb, depth);
      r.image_row    = project_coord(y, depth);
      if (r.left_column > peak_left_q) peak_left_q = r.left_column;
      if (r.right_column > peak_right_q) peak_right_q = r.right_column;
      if (r.image_row > peak_row_q) peak_row_q = r.image_row;
    end
    r.max_left_column  = peak_left_q;
    r.max_right_column = peak_right_q;
    r.max_image_row    = peak_row_q;
    r.divide_fault     = fault;
    return r;
  endfunction

  task automatic report(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      plane_a_q    = PLANE_A_RST;
      plane_b_q    = PLANE_B_RST;
      plane_c_q    = PLANE_C_RST;
      plane_d_q    = PLANE_D_RST;
      pitch_q      = PITCH_RST;
      focal_q      = FOCAL_RST;
      baseline_q   = BASELINE_RST;
      peak_left_q  = '0;
      peak_right_q = '0;
      peak_row_q   = '0;
      expected_px.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_px.size() == 0) begin
          report("result item arrived with none expected");
        end else begin
          want = expected_px.pop_front();
          check_field("left_column", out_item_i.left_column, want.left_column);
          check_field("right_column", out_item_i.right_column, want.right_column);
          check_field("image_row", out_item_i.image_row, want.image_row);
          check_field("max_left_column", out_item_i.max_left_column, want.max_left_column);
          check_field("max_right_column", out_item_i.max_right_column, want.max_right_column);
          check_field("max_image_row", out_item_i.max_image_row, want.max_image_row);
          check_field("divide_fault", out_item_i.divide_fault, want.divide_fault);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PLANE_A:         plane_a_q  = cfg_data_i;
          CFG_PLANE_B:         plane_b_q  = cfg_data_i;
          CFG_PLANE_C:         plane_c_q  = cfg_data_i;
          CFG_PLANE_D:         plane_d_q  = cfg_data_i;
          CFG_PIXEL_PITCH:     pitch_q    = cfg_data_i[30:0];
          CFG_FOCAL_LENGTH:    focal_q    = cfg_data_i[30:0];
          CFG_STEREO_BASELINE: baseline_q = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_px.insert(expected_px.size(), predict_pixel(in_item_i));
      end
      outstanding_o <= expected_px.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// stimulus and verdict for the plane to stereo pixel projection unit
`timescale 1ns / 1ps

module testbench;

  import pspp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int RANDOM_BATCHES = 31;
  localparam int BATCH_ITEMS    = 50;
  localparam int DRAIN_CYCLES   = 130;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  int outstanding;
  int mismatches;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  always #6 clk = ~clk;

  plane_to_stereo_pixel_projection_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pspp_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // drops valid and holds off until every pending result item is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] d,
                                input logic [31:0] pitch, input logic [31:0] focal,
                                input logic [31:0] base);
    wait_drained();
    write_reg(CFG_PLANE_A, a);
    write_reg(CFG_PLANE_B, b);
    write_reg(CFG_PLANE_C, c);
    write_reg(CFG_PLANE_D, d);
    write_reg(CFG_PIXEL_PITCH, pitch);
    write_reg(CFG_FOCAL_LENGTH, focal);
    write_reg(CFG_STEREO_BASELINE, base);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_point(input logic [7:0] col, input logic [7:0] row);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(120, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{grid_col: col, grid_row: row};
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly a plausible range, sometimes any bit pattern
  function automatic logic [31:0] rand_reg(bit is_signed, int unsigned lo, int unsigned hi);
    logic [31:0] v;
    if ($urandom_range(4) == 0) return $urandom();
    v = $urandom_range(hi, lo);
    if (is_signed && $urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic logic [7:0] random_index();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_settings();
    logic [31:0] c;
    c = ($urandom_range(15) == 0) ? 32'd0 : rand_reg(1, 1 << 12, 1 << 18);
    apply_settings(rand_reg(1, 0, 1 << 17), rand_reg(1, 0, 1 << 17), c,
                   rand_reg(1, 1 << 16, 1 << 24), rand_reg(0, 1 << 12, 1 << 18),
                   rand_reg(0, 1 << 14, 1 << 26), rand_reg(0, 0, 1 << 24));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: unit depth, unit focal length and baseline
    send_point(8'd0, 8'd0);
    send_point(8'd255, 8'd255);
    send_point(8'd1, 8'd0);
    send_point(8'd0, 8'd1);
    send_point(8'd128, 8'd7);

    // zero plane_c divisor
    apply_settings(PLANE_A_RST, PLANE_B_RST, 32'd0, PLANE_D_RST, 32'(PITCH_RST),
                   32'(FOCAL_RST), 32'(BASELINE_RST));
    send_point(8'd3, 8'd4);
    send_point(8'd255, 8'd0);

    // numerator of zero gives zero depth
    apply_settings(32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'(PITCH_RST),
                   32'(FOCAL_RST), 32'(BASELINE_RST));
    send_point(8'd10, 8'd10);

    // write to an index with no register behind it
    wait_drained();
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;

    // depth saturates, coordinates collapse toward zero
    apply_settings(32'd0, 32'd0, 32'h0000_0001, 32'h8000_0000, 32'(PITCH_RST),
                   32'(FOCAL_RST), 32'(BASELINE_RST));
    send_point(8'd255, 8'd255);
    send_point(8'd0, 8'd0);

    // tiny depth with top bits set on the unsigned registers: nonzero vectors saturate
    apply_settings(32'd0, 32'd0, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(8'd255, 8'd255);
    send_point(8'd1, 8'd1);
    send_point(8'd0, 8'd0);

    // signed coefficient extremes
    apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'(FOCAL_RST), 32'd0);
    send_point(8'd255, 8'd0);
    send_point(8'd0, 8'd255);
    send_point(8'd255, 8'd255);

    for (int b = 0; b < RANDOM_BATCHES; b++) begin
      if (b < 11) begin
        tx_idle_pct = 30;
        rx_idle_pct = 81;
      end else if (b < 21) begin
        tx_idle_pct = 81;
        rx_idle_pct = 30;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (b)
        0: apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: apply_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'd0, 32'd0, 32'd0);
        default: random_settings();
      endcase
      for (int n = 0; n < BATCH_ITEMS; n++) begin
        // now and then let the pipe run dry mid-batch
        if ($urandom_range(39) == 0) wait_drained();
        send_point(random_index(), random_index());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pspp_pkg.sv
rtl/pspp_div.sv
rtl/pspp_ctrl.sv
rtl/plane_to_stereo_pixel_projection_unit.sv
rtl/pspp_checker.sv
tb/pspp_checker.sv
tb/testbench.sv
